// ===== sv/cau_pkg.sv =====
// Package for the complex arithmetic unit: opcodes, the lane word carried
// down the divide/root cell chain, and the saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

	localparam int FRAC_BITS_DEF = 8;
	// quotient/root digits resolved by the cell chain
	localparam int NCELL = 17;

	localparam logic [2:0] OP_ADDC = 3'd0;
	localparam logic [2:0] OP_ADDR = 3'd1;
	localparam logic [2:0] OP_MULC = 3'd2;
	localparam logic [2:0] OP_MULR = 3'd3;
	localparam logic [2:0] OP_DIVC = 3'd4;
	localparam logic [2:0] OP_DIVR = 3'd5;
	localparam logic [2:0] OP_MAG  = 3'd6;
	localparam logic [2:0] OP_EQ   = 3'd7;

	// one word in flight through the cells
	typedef struct packed {
		logic [2:0]         op;
		logic signed [33:0] sre;      // add/multiply result, real
		logic signed [33:0] sim;      // add/multiply result, imaginary
		logic               eq;
		logic               dz;
		logic               sa_re;    // sign of a_re
		logic               sa_im;    // sign of a_im
		logic               neg_re;   // quotient sign
		logic               neg_im;
		logic               dov_re;   // quotient beyond 17 bits
		logic               dov_im;
		logic [32:0]        y;        // twice the divisor norm
		logic [16:0]        xlo_re;   // low dividend bits, shifted in one per cell
		logic [16:0]        xlo_im;
		logic [33:0]        rem_re;
		logic [33:0]        rem_im;
		logic [16:0]        q_re;
		logic [16:0]        q_im;
		logic [33:0]        v;        // radicand, two bits per cell
		logic [18:0]        srem;
		logic [16:0]        sroot;
	} cau_lane_t;

	// clamp to 16-bit signed; bit 16 flags saturation
	function automatic logic [16:0] sat16(input logic signed [33:0] x);
		if (x > 34'sd32767) begin
			return {1'b1, 16'h7FFF};
		end else if (x < -34'sd32768) begin
			return {1'b1, 16'h8000};
		end
		return {1'b0, x[15:0]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/complex_arithmetic_unit_top.sv =====
// Complex arithmetic unit top: multiply stage, sum stage, divide setup, a chain
// of cau_cell stages and the result register. Depends on cau_pkg, cau_cell.
//
//  channel  | direction | tdata                        | tuser
//  s_axis   | in        | a_re, a_im, b_re, b_im       | func
//  m_axis   | out       | r_re, r_im                   | match, overflow, div_zero
//
// One word per cycle unless the output stalls; the pipeline has three setup stages, 17 chain
// cells (one quotient bit and one root digit each) and the output register.
// The whole pipeline advances together whenever the output register is empty
// or taken; a stalled output holds every stage.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_top #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
	input  wire  [2:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // r_re, r_im
	output logic [2:0]  m_axis_tuser    // match, overflow, div_zero
);
	import cau_pkg::*;

	localparam int XW = 34 + FRAC_BITS;
	localparam int LW = 51 + FRAC_BITS;
	localparam logic signed [33:0] HALF = (FRAC_BITS > 0) ? 34'sd1 <<< (FRAC_BITS - 1) : 34'sd0;

	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: products
	logic signed [15:0] ar, ai, br, bi, bi_eff;
	logic [2:0]         op_s1;
	logic               v_s1;
	logic signed [15:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [31:0] prr_s1, pii_s1, pri_s1, pir_s1, paa_s1, pai_s1, pbr_s1, pbi_s1;

	assign ar     = s_axis_tdata[15:0];
	assign ai     = s_axis_tdata[31:16];
	assign br     = s_axis_tdata[47:32];
	assign bi     = s_axis_tdata[63:48];
	assign bi_eff = (s_axis_tuser == OP_DIVR) ? 16'sd0 : bi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= s_axis_tuser;
			ar_s1  <= ar;
			ai_s1  <= ai;
			br_s1  <= br;
			bi_s1  <= bi;
			prr_s1 <= ar * br;
			pii_s1 <= ai * bi_eff;
			pri_s1 <= ar * bi_eff;
			pir_s1 <= ai * br;
			paa_s1 <= ar * ar;
			pai_s1 <= ai * ai;
			pbr_s1 <= br * br;
			pbi_s1 <= bi_eff * bi_eff;
		end
	end

	// stage 2: sums, rounded products, divide numerators and norms
	logic signed [33:0] sre_c, sim_c;
	logic [2:0]         op_s2;
	logic               v_s2, eq_s2, sa_re_s2, sa_im_s2;
	logic signed [33:0] sre_s2, sim_s2, nre_s2, nim_s2;
	logic [31:0]        den_s2, vv_s2;

	always_comb begin
		case (op_s1)
			OP_ADDC: begin
				sre_c = 34'(ar_s1) + 34'(br_s1);
				sim_c = 34'(ai_s1) + 34'(bi_s1);
			end
			OP_ADDR: begin
				sre_c = 34'(ar_s1) + 34'(br_s1);
				sim_c = 34'(ai_s1);
			end
			OP_MULC: begin
				sre_c = (34'(prr_s1) - 34'(pii_s1) + HALF) >>> FRAC_BITS;
				sim_c = (34'(pri_s1) + 34'(pir_s1) + HALF) >>> FRAC_BITS;
			end
			OP_MULR: begin
				sre_c = (34'(prr_s1) + HALF) >>> FRAC_BITS;
				sim_c = (34'(pir_s1) + HALF) >>> FRAC_BITS;
			end
			default: begin
				sre_c = 34'sd0;
				sim_c = 34'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2    <= op_s1;
			sre_s2   <= sre_c;
			sim_s2   <= sim_c;
			nre_s2   <= 34'(prr_s1) + 34'(pii_s1);
			nim_s2   <= 34'(pir_s1) - 34'(pri_s1);
			den_s2   <= {1'b0, pbr_s1[30:0]} + {1'b0, pbi_s1[30:0]};
			vv_s2    <= {1'b0, paa_s1[30:0]} + {1'b0, pai_s1[30:0]};
			eq_s2    <= (ar_s1 == br_s1) && (ai_s1 == bi_s1);
			sa_re_s2 <= ar_s1[15];
			sa_im_s2 <= ai_s1[15];
		end
	end

	// stage 3: scaled dividends, range check, chain entry word
	logic signed [33:0] mre, mim;
	logic [XW-1:0]      xre, xim;
	logic [32:0]        y_c;
	logic               dov_re, dov_im;
	cau_lane_t          lane_c;
	cau_lane_t          lane_s3;
	logic               v_s3;

	always_comb begin
		mre    = nre_s2[33] ? -nre_s2 : nre_s2;
		mim    = nim_s2[33] ? -nim_s2 : nim_s2;
		xre    = (XW'(mre[31:0]) << (FRAC_BITS + 1)) + XW'(den_s2);
		xim    = (XW'(mim[31:0]) << (FRAC_BITS + 1)) + XW'(den_s2);
		y_c    = {den_s2, 1'b0};
		dov_re = LW'(xre) >= (LW'(y_c) << NCELL);
		dov_im = LW'(xim) >= (LW'(y_c) << NCELL);

		lane_c        = '0;
		lane_c.op     = op_s2;
		lane_c.sre    = sre_s2;
		lane_c.sim    = sim_s2;
		lane_c.eq     = eq_s2;
		lane_c.dz     = (den_s2 == 32'd0);
		lane_c.sa_re  = sa_re_s2;
		lane_c.sa_im  = sa_im_s2;
		lane_c.neg_re = nre_s2[33];
		lane_c.neg_im = nim_s2[33];
		lane_c.dov_re = dov_re;
		lane_c.dov_im = dov_im;
		lane_c.y      = y_c;
		lane_c.xlo_re = xre[NCELL-1:0];
		lane_c.xlo_im = xim[NCELL-1:0];
		lane_c.rem_re = dov_re ? 34'd0 : 34'(xre >> NCELL);
		lane_c.rem_im = dov_im ? 34'd0 : 34'(xim >> NCELL);
		lane_c.v      = {2'b00, vv_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s3 <= lane_c;
		end
	end

	// cell chain
	cau_lane_t lane_k [NCELL+1];
	logic      vld_k  [NCELL+1];

	assign lane_k[0] = lane_s3;
	assign vld_k[0]  = v_s3;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		cau_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vld_k[k]),
			.in_lane  (lane_k[k]),
			.out_valid(vld_k[k+1]),
			.out_lane (lane_k[k+1])
		);
	end

	// result select and saturation
	cau_lane_t          fl;
	logic signed [33:0] qre, qim, dre, dim;
	logic [17:0]        rt;
	logic [16:0]        s_re, s_im;
	logic [15:0]        r_re, r_im;
	logic               f_ovf, f_match, f_dz;

	always_comb begin
		fl      = lane_k[NCELL];
		qre     = 34'(fl.q_re);
		qim     = 34'(fl.q_im);
		dre     = fl.dov_re ? 34'sd40000 : qre;
		dim     = fl.dov_im ? 34'sd40000 : qim;
		dre     = fl.neg_re ? -dre : dre;
		dim     = fl.neg_im ? -dim : dim;
		rt      = 18'(fl.sroot) + 18'(fl.srem > 19'(fl.sroot));
		s_re    = '0;
		s_im    = '0;
		f_match = 1'b0;
		f_dz    = 1'b0;
		case (fl.op)
			OP_ADDC, OP_ADDR, OP_MULC, OP_MULR: begin
				s_re = sat16(fl.sre);
				s_im = sat16(fl.sim);
			end
			OP_DIVC, OP_DIVR: begin
				if (fl.dz) begin
					f_dz = 1'b1;
					s_re = {1'b1, fl.sa_re ? 16'h8000 : 16'h7FFF};
					s_im = {1'b1, fl.sa_im ? 16'h8000 : 16'h7FFF};
				end else begin
					s_re = sat16(dre);
					s_im = sat16(dim);
				end
			end
			OP_MAG: begin
				s_re = sat16(34'(rt));
			end
			default: begin
				f_match = fl.eq;
			end
		endcase
		r_re  = s_re[15:0];
		r_im  = s_im[15:0];
		f_ovf = s_re[16] | s_im[16];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= vld_k[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {r_im, r_re};
			m_axis_tuser <= {f_dz, f_ovf, f_match};
		end
	end

`ifndef SYNTHESIS
	a_ready_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_dz_sets_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
		else $error("divide by zero without overflow flag");

	a_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		m_axis_tdata == 32'd0 && !m_axis_tuser[1] && !m_axis_tuser[2])
		else $error("match word carries data or flags");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && !m_axis_tready) |-> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== sv/cau_cell.sv =====
// One cell of the chain: a restoring divide step for each quotient and one
// square-root digit step. Depends on cau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cau_cell #(
	parameter int IDX = 0
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                in_valid,
	input  cau_pkg::cau_lane_t in_lane,
	output logic               out_valid,
	output cau_pkg::cau_lane_t out_lane
);
	import cau_pkg::*;

	localparam int XB = NCELL - 1 - IDX;
	localparam int VB = 2 * NCELL - 1 - 2 * IDX;

	cau_lane_t   nxt;
	logic [33:0] tre, tim;
	logic [20:0] ts, trial;

	// divide and root steps
	always_comb begin
		nxt = in_lane;
		tre = {in_lane.rem_re[32:0], in_lane.xlo_re[XB]};
		tim = {in_lane.rem_im[32:0], in_lane.xlo_im[XB]};
		if (tre >= {1'b0, in_lane.y}) begin
			nxt.rem_re = tre - {1'b0, in_lane.y};
			nxt.q_re   = {in_lane.q_re[15:0], 1'b1};
		end else begin
			nxt.rem_re = tre;
			nxt.q_re   = {in_lane.q_re[15:0], 1'b0};
		end
		if (tim >= {1'b0, in_lane.y}) begin
			nxt.rem_im = tim - {1'b0, in_lane.y};
			nxt.q_im   = {in_lane.q_im[15:0], 1'b1};
		end else begin
			nxt.rem_im = tim;
			nxt.q_im   = {in_lane.q_im[15:0], 1'b0};
		end
		ts    = {in_lane.srem, in_lane.v[VB -: 2]};
		trial = {2'b00, in_lane.sroot, 2'b01};
		if (ts >= trial) begin
			nxt.srem  = 19'(ts - trial);
			nxt.sroot = {in_lane.sroot[15:0], 1'b1};
		end else begin
			nxt.srem  = ts[18:0];
			nxt.sroot = {in_lane.sroot[15:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_lane <= nxt;
		end
	end

endmodule
`default_nettype wire
